[hw/rtl/srti_pkg.sv]
// Package for the sorted region table: command and status codes, entry layout,
// controller states and default table depth. No dependencies.
package srti_pkg;

  localparam int unsigned MaxEntriesDefault = 8;
  localparam int unsigned AddrBits = 64;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned SlotBits = 3;
  localparam int unsigned CountBits = 4;

  typedef enum logic {
    CmdClear  = 1'b0,
    CmdInsert = 1'b1
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusFull    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StWrNew,
    StResp
  } state_e;

  typedef struct packed {
    logic [AddrBits-1:0] base;
    logic [AddrBits-1:0] length;
  } entry_t;

endpackage

[hw/rtl/sorted_region_table_insert.sv]
// Top level of the sorted region table. Depends on srti_pkg and srti_ram.
//
// Keeps up to MaxEntries address regions (64-bit base and size) sorted by base in
// one RAM and answers each command with a status, the slot used and the entry count.
// A clear or a rejected region (zero size, wrap past the top of the address space,
// or full table) goes from idle straight to the response state. An insert goes
// through the compare, write and response states (an empty table skips the
// compare state): the controller walks down from the top of the table, one RAM
// read-compare-write per cycle through the single read and single write port,
// moving each larger entry up one slot, then writes the new region and checks it
// against its two neighbors (the last entry read and the last entry moved). Output
// valid rises as the response state returns to idle, and the next input can be
// taken from that same cycle on. The output sits in a register, so a new input is
// taken while a result still waits for its transfer; the result of that new input
// then holds until the waiting one is transferred.
module sorted_region_table_insert
  import srti_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [AddrBits-1:0]   region_base_i,
  input  logic [AddrBits-1:0]   region_size_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StatusBits-1:0] status_o,
  output logic [SlotBits-1:0]   slot_o,
  output logic [CountBits-1:0]  entry_count_o
);

  localparam int unsigned Aw = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned Cw = $clog2(MaxEntries + 1);
  localparam int unsigned Ew = $bits(entry_t);

  state_e state_q, state_d;
  logic [Cw-1:0] count_q, count_d;
  logic [Cw-1:0] pos_q, pos_d;
  logic has_prev_q, has_prev_d;
  logic has_next_q, has_next_d;
  logic out_valid_q, out_valid_d;

  logic [AddrBits-1:0] base_q, base_d;
  logic [AddrBits-1:0] size_q, size_d;
  entry_t prev_q, prev_d;
  entry_t next_q, next_d;
  status_e res_status_q, res_status_d;
  logic [Cw-1:0] res_slot_q, res_slot_d;
  logic [StatusBits-1:0] status_q, status_d;
  logic [SlotBits-1:0] slot_q, slot_d;
  logic [CountBits-1:0] ecount_q, ecount_d;

  logic ram_we, ram_re;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;
  logic [Ew-1:0] ram_rdata_raw;

  logic [AddrBits:0] end_sum;
  logic region_bad;
  logic ovl_prev, ovl_next;
  logic in_xfer, out_xfer;

  srti_ram #(
    .Width(Ew),
    .Depth(MaxEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;

  assign end_sum = {1'b0, region_base_i} + {1'b0, region_size_i};
  assign region_bad = (region_size_i == '0) || end_sum[AddrBits];

  assign ovl_prev = has_prev_q && (prev_q.length > (base_q - prev_q.base));
  assign ovl_next = has_next_q && (size_q > (next_q.base - base_q));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d = pos_q;
    has_prev_d = has_prev_q;
    has_next_d = has_next_q;
    out_valid_d = out_valid_q;
    base_d = base_q;
    size_d = size_q;
    prev_d = prev_q;
    next_d = next_q;
    res_status_d = res_status_q;
    res_slot_d = res_slot_q;
    status_d = status_q;
    slot_d = slot_q;
    ecount_d = ecount_q;
    ram_we = 1'b0;
    ram_waddr = Aw'(pos_q);
    ram_wdata = '{base: base_q, length: size_q};
    ram_re = 1'b0;
    ram_raddr = Aw'(count_q - Cw'(1));

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          base_d = region_base_i;
          size_d = region_size_i;
          res_slot_d = '0;
          has_prev_d = 1'b0;
          has_next_d = 1'b0;
          pos_d = count_q;
          if (command_i == CmdClear) begin
            count_d = '0;
            res_status_d = StatusOk;
            state_d = StResp;
          end else if (region_bad) begin
            res_status_d = StatusInvalid;
            state_d = StResp;
          end else if (count_q >= Cw'(MaxEntries)) begin
            res_status_d = StatusFull;
            state_d = StResp;
          end else if (count_q == '0) begin
            state_d = StWrNew;
          end else begin
            ram_re = 1'b1;
            state_d = StCmp;
          end
        end
      end
      StCmp: begin
        if (ram_rdata.base > base_q) begin
          ram_we = 1'b1;
          ram_wdata = ram_rdata;
          next_d = ram_rdata;
          has_next_d = 1'b1;
          pos_d = pos_q - Cw'(1);
          if (pos_q == Cw'(1)) begin
            state_d = StWrNew;
          end else begin
            ram_re = 1'b1;
            ram_raddr = Aw'(pos_q - Cw'(2));
          end
        end else begin
          prev_d = ram_rdata;
          has_prev_d = 1'b1;
          state_d = StWrNew;
        end
      end
      StWrNew: begin
        ram_we = 1'b1;
        count_d = count_q + Cw'(1);
        res_slot_d = pos_q;
        res_status_d = (ovl_prev || ovl_next) ? StatusInvalid : StatusOk;
        state_d = StResp;
      end
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d = res_status_q;
          slot_d = SlotBits'(res_slot_q);
          ecount_d = CountBits'(count_q);
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      pos_q <= '0;
      has_prev_q <= 1'b0;
      has_next_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q <= pos_d;
      has_prev_q <= has_prev_d;
      has_next_q <= has_next_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    size_q <= size_d;
    prev_q <= prev_d;
    next_q <= next_d;
    res_status_q <= res_status_d;
    res_slot_q <= res_slot_d;
    status_q <= status_d;
    slot_q <= slot_d;
    ecount_q <= ecount_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign slot_o = slot_q;
  assign entry_count_o = ecount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cw'(MaxEntries))
    else $error("entry count above table depth");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StCmp || state_q == StWrNew))
    else $error("table write outside insert states");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWrNew |=> count_q == $past(count_q) + Cw'(1))
    else $error("insert did not raise the count by one");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWrNew |-> pos_q < Cw'(MaxEntries) && pos_q <= count_q)
    else $error("new region slot out of range");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResp && res_status_q == StatusFull) |-> count_q == Cw'(MaxEntries))
    else $error("full status with room in the table");

endmodule

[hw/rtl/srti_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module srti_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 8,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[bench/sorted_region_table_insert_tb.sv]
// Testbench for sorted_region_table_insert: directed and random clear/insert traffic
// under several idle and stall mixes, checked against an in-bench region table model.
// Depends on srti_pkg and the RTL of the block; needs no files.
module sorted_region_table_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srti_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldOffCycles = 150;

  typedef struct {
    status_e               status;
    logic [SlotBits-1:0]   slot;
    logic [CountBits-1:0]  count;
  } table_answer_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  command_i = 1'b0;
  logic [AddrBits-1:0]   region_base_i = '0;
  logic [AddrBits-1:0]   region_size_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [StatusBits-1:0] status_o;
  logic [SlotBits-1:0]   slot_o;
  logic [CountBits-1:0]  entry_count_o;

  logic [AddrBits-1:0] table_base [MaxEntriesDefault];
  logic [AddrBits-1:0] table_size [MaxEntriesDefault];
  int unsigned         table_fill = 0;

  table_answer_t answer_q[$];
  table_answer_t head_answer;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        holding_off = 1'b0;
  event        holdoff_ev;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned ok_count = 0;
  int unsigned invalid_count = 0;
  int unsigned full_count = 0;

  sorted_region_table_insert u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .region_base_i (region_base_i),
    .region_size_i (region_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [AddrBits-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic table_answer_t apply_table_command(cmd_e cmd, logic [AddrBits-1:0] base,
                                                        logic [AddrBits-1:0] size);
    table_answer_t ans;
    int unsigned   pos;
    logic          overlap;
    ans.slot = '0;
    overlap = 1'b0;
    if (cmd == CmdClear) begin
      table_fill = 0;
      ans.status = StatusOk;
      ans.count = '0;
      return ans;
    end
    ans.count = CountBits'(table_fill);
    if (size == '0 || size > ~base) begin
      ans.status = StatusInvalid;
      return ans;
    end
    if (table_fill >= MaxEntriesDefault) begin
      ans.status = StatusFull;
      return ans;
    end
    pos = table_fill;
    while (pos > 0 && table_base[pos-1] > base) begin
      table_base[pos] = table_base[pos-1];
      table_size[pos] = table_size[pos-1];
      pos--;
    end
    table_base[pos] = base;
    table_size[pos] = size;
    table_fill++;
    if (pos > 0 && table_size[pos-1] > base - table_base[pos-1]) overlap = 1'b1;
    if (pos + 1 < table_fill && size > table_base[pos+1] - base) overlap = 1'b1;
    ans.status = overlap ? StatusInvalid : StatusOk;
    ans.slot = SlotBits'(pos);
    ans.count = CountBits'(table_fill);
    return ans;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
  task automatic send_item(input cmd_e cmd, input logic [AddrBits-1:0] base,
                           input logic [AddrBits-1:0] size);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    region_base_i <= base;
    region_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    answer_q.push_back(apply_table_command(cmd, base, size));
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (answer_q.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (holding_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always begin
    @(holdoff_ev);
    @(posedge clk_i);
    holding_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    holding_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d entry_count %0d",
               status_o, slot_o, entry_count_o);
        fail_count++;
      end else begin
        head_answer = answer_q.pop_front();
        checked_count++;
        case (head_answer.status)
          StatusOk:      ok_count++;
          StatusInvalid: invalid_count++;
          default:       full_count++;
        endcase
        if (status_o != head_answer.status) begin
          $error("status: expected %0d, got %0d", head_answer.status, status_o);
          fail_count++;
        end
        if (slot_o != head_answer.slot) begin
          $error("slot: expected %0d, got %0d", head_answer.slot, slot_o);
          fail_count++;
        end
        if (entry_count_o != head_answer.count) begin
          $error("entry_count: expected %0d, got %0d", head_answer.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  // Rounds of clear followed by inserts; most inserts land near one anchor so that neighbors,
  // overlaps and shifts occur, the rest are wide, tiny, empty, duplicate or near the top.
  task automatic send_random_items(input int unsigned count);
    int unsigned         i;
    int unsigned         pick;
    int unsigned         left;
    logic [AddrBits-1:0] base;
    logic [AddrBits-1:0] size;
    logic [AddrBits-1:0] anchor;
    logic [AddrBits-1:0] last_base;
    left = 0;
    anchor = '0;
    last_base = '0;
    for (i = 0; i < count; i++) begin
      if (left == 0) begin
        send_item(CmdClear, rand_addr(), rand_addr());
        left = $urandom_range(3, 12);
        anchor = rand_addr() & 64'hFFFF_FFFF_FFF0_0000;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          base = anchor + 64'($urandom_range(31)) * 64'h1000;
          size = 64'($urandom_range(1, 32'h1800));
        end else if (pick < 72) begin
          base = rand_addr();
          size = rand_addr();
        end else if (pick < 82) begin
          base = rand_addr();
          size = 64'($urandom_range(1, 16));
        end else if (pick < 87) begin
          base = rand_addr();
          size = '0;
        end else if (pick < 94) begin
          base = last_base;
          size = 64'($urandom_range(1, 256));
        end else begin
          base = ~64'($urandom_range(255));
          size = 64'($urandom_range(1, 300));
        end
        send_item(CmdInsert, base, size);
        last_base = base;
        left--;
      end
    end
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    send_item(CmdClear, '0, '0);
    send_item(CmdInsert, 64'h1000, '0);
    send_item(CmdInsert, '1, 64'h1);
    send_item(CmdInsert, '0, '1);
    send_item(CmdInsert, 64'h100, 64'h10);
    send_item(CmdClear, '1, '1);
    send_item(CmdInsert, 64'h8000, 64'h100);
    send_item(CmdInsert, 64'h1000, 64'h100);
    send_item(CmdInsert, 64'h10000, 64'h100);
    send_item(CmdInsert, 64'h0F80, 64'h100);
    send_item(CmdInsert, 64'h8000, 64'h10);
    send_item(CmdInsert, 64'hFFFF_FFFF_FFFF_FF00, 64'h100);
    send_item(CmdInsert, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF);
    send_item(CmdInsert, 64'h20000, 64'h1);
    send_item(CmdInsert, 64'h30000, 64'h1);
    send_item(CmdInsert, 64'h40000, 64'h1);
    send_item(CmdInsert, 64'h50000, '0);
    send_item(CmdInsert, '1, '1);
    send_item(CmdClear, '0, '0);
    send_item(CmdInsert, 64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA);
    send_item(CmdInsert, 64'h0, 64'h5555_5555_5555_5555);
    wait_drained();
  endtask

  task automatic test_steady_flow();
    gap_pct = 0;
    stall_pct = 0;
    send_random_items(120);
  endtask

  task automatic test_sender_gaps();
    gap_pct = 85;
    stall_pct = 0;
    send_random_items(120);
  endtask

  task automatic test_receiver_stalls();
    gap_pct = 0;
    stall_pct = 85;
    send_random_items(120);
  endtask

  task automatic test_both_idle();
    gap_pct = 27;
    stall_pct = 27;
    send_random_items(120);
  endtask

  task automatic test_output_holdoff();
    gap_pct = 0;
    stall_pct = 0;
    -> holdoff_ev;
    send_random_items(24);
    wait_drained();
  endtask

  task automatic test_drain_pauses();
    int unsigned burst;
    gap_pct = 10;
    stall_pct = 30;
    for (burst = 0; burst < 5; burst++) begin
      send_random_items(14);
      wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_steady_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_holdoff();
    test_drain_pauses();
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (answer_q.size() != 0) begin
      $error("%0d results never arrived", answer_q.size());
      fail_count++;
    end
    $display("Sent %0d clear/insert transfers, checked %0d results", sent_count, checked_count);
    $display("Outcomes: %0d ok, %0d invalid, %0d full; %0d mismatches",
             ok_count, invalid_count, full_count, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
